FILE: sv/gal_pkg.sv
// shared types, constants and command/status structs for the alignment core
`timescale 1ns / 1ps
package gal_pkg;
    localparam int MAX_LEN = 32;
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int TAB_DEPTH = (MAX_LEN + 1) * (MAX_LEN + 1);
    localparam int TAB_AW = $clog2(TAB_DEPTH);
    localparam int SCORE_W = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] REQ_PATTERN = 2'd0;
    localparam logic [1:0] REQ_TEXT = 2'd1;
    localparam logic [1:0] REQ_ALIGN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TB = 2'd3;

    localparam logic [1:0] OP_MATCH = 2'd0;
    localparam logic [1:0] OP_MISMATCH = 2'd1;
    localparam logic [1:0] OP_INSERTION = 2'd2;
    localparam logic [1:0] OP_DELETION = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load_pat;
        logic load_txt;
        logic clear_counts;
        logic fill_start;   // set h,v to start of fill
        logic fill_write;   // write current cell, advance
        logic tb_start;
        logic tb_issue;     // read cells around (h,v)
        logic tb_step;      // decide and move
        logic out_load;     // capture a result beat
        logic out_score_only;
    } gal_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_done;
        logic tb_done;
        logic tb_last;
        logic empty;
    } gal_sts_t;
endpackage

FILE: sv/gal_stream_if.sv
// valid/ready channel carrying one beat of payload
`timescale 1ns / 1ps
interface gal_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] symbol;
    modport source (output valid, output req_type, output symbol, input ready);
    modport sink (input valid, input req_type, input symbol, output ready);
endinterface

interface gal_out_if;
    logic                        valid;
    logic                        ready;
    logic [gal_pkg::SCORE_W-1:0] score;
    logic [1:0]                  edit_op;
    logic                        op_valid;
    logic                        last;
    modport source (output valid, output score, output edit_op, output op_valid,
                    output last, input ready);
    modport sink (input valid, input score, input edit_op, input op_valid,
                  input last, output ready);
endinterface

FILE: sv/gal_ram.sv
// generic single-write dual-read ram with registered reads
`timescale 1ns / 1ps
module gal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

FILE: sv/gal_datapath.sv
// stores, score table, cell update, traceback and output register
`timescale 1ns / 1ps
module gal_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gal_pkg::gal_cmd_t            cmd,
    output gal_pkg::gal_sts_t            sts,
    input  logic [7:0]                   symbol,
    input  logic [7:0]                   del_pen,
    input  logic [7:0]                   ins_pen,
    input  logic [7:0]                   mis_pen,
    input  logic                         tb_en,
    output logic [gal_pkg::SCORE_W-1:0]  score,
    output logic [1:0]                   edit_op,
    output logic                         op_valid,
    output logic                         last
);
    localparam int LW = gal_pkg::LEN_W;
    localparam int AW = gal_pkg::TAB_AW;
    localparam int SW = gal_pkg::SCORE_W;
    localparam int XW = gal_pkg::IDX_W;

    logic [LW-1:0] pcnt_reg, tcnt_reg;
    logic [LW-1:0] h_reg, v_reg;
    logic [SW-1:0] score_reg;
    logic [SW-1:0] out_score_reg;
    logic [1:0]    out_op_reg;
    logic          out_opv_reg, out_last_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [SW-1:0] wdata, rd_a, rd_b;

    // table address h*(P+1)+v, narrow multiply
    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] hh,
                                              input logic [LW-1:0] vv,
                                              input logic [LW-1:0] pc);
        logic [2*LW+1:0] prod;
        prod = {1'b0, hh} * {1'b0, pc + 1'b1} + (2*LW+2)'(vv);
        return prod[AW-1:0];
    endfunction

    gal_ram #(.WIDTH(SW), .DEPTH(gal_pkg::TAB_DEPTH)) u_tab (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(raddr_a), .rdata_a(rd_a), .raddr_b(raddr_b), .rdata_b(rd_b)
    );

    // read a: (h,v-1)  read b: (h-1,v); diagonal via held previous-row value
    logic [LW-1:0] hm1, vm1;
    assign hm1 = h_reg - 1'b1;
    assign vm1 = v_reg - 1'b1;

    always_comb
    begin
        raddr_a = addr_of(h_reg, vm1, pcnt_reg);
        raddr_b = addr_of(hm1, v_reg, pcnt_reg);
        if (cmd.tb_issue && h_reg == '0)
        begin
            raddr_b = addr_of(h_reg, v_reg, pcnt_reg);
        end
    end

    // pattern in the lower half of the symbol ram, text in the upper half
    logic          sym_we;
    logic [XW:0]   sym_waddr, sym_raddr_p, sym_raddr_t;
    logic [7:0]    pat_rd, txt_rd;
    assign sym_we = (cmd.load_pat && pcnt_reg != LW'(gal_pkg::MAX_LEN)) ||
                    (cmd.load_txt && tcnt_reg != LW'(gal_pkg::MAX_LEN));
    assign sym_waddr = cmd.load_txt ? {1'b1, tcnt_reg[XW-1:0]} : {1'b0, pcnt_reg[XW-1:0]};
    assign sym_raddr_p = {1'b0, vm1[XW-1:0]};
    assign sym_raddr_t = {1'b1, hm1[XW-1:0]};

    gal_ram #(.WIDTH(8), .DEPTH(2 * gal_pkg::MAX_LEN)) u_sym (
        .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(symbol),
        .raddr_a(sym_raddr_p), .rdata_a(pat_rd), .raddr_b(sym_raddr_t), .rdata_b(txt_rd)
    );

    // diagonal (h-1,v-1) is the up read of the previous cell in the row
    logic [SW-1:0] dia_val_reg;
    logic          eq;
    logic [SW-1:0] c_del, c_ins, c_dia, best, cur_reg;
    assign eq = (pat_rd == txt_rd);
    assign c_del = rd_a + SW'(del_pen);
    assign c_ins = rd_b + SW'(ins_pen);
    assign c_dia = dia_val_reg + (eq ? '0 : SW'(mis_pen));

    always_comb
    begin
        best = c_dia;
        if (c_ins < best) best = c_ins;
        if (c_del < best) best = c_del;
        if (h_reg == '0 && v_reg == '0) best = '0;
        else if (h_reg == '0) best = c_del;
        else if (v_reg == '0) best = c_ins;
    end

    assign we = cmd.fill_write;
    assign waddr = addr_of(h_reg, v_reg, pcnt_reg);
    assign wdata = best;

    // traceback decision against the held value of the current cell
    logic [1:0] tb_op;
    always_comb
    begin
        if (h_reg == '0)
            tb_op = gal_pkg::OP_DELETION;
        else if (v_reg == '0)
            tb_op = gal_pkg::OP_INSERTION;
        else if (cur_reg == c_del)
            tb_op = gal_pkg::OP_DELETION;
        else if (cur_reg == c_ins)
            tb_op = gal_pkg::OP_INSERTION;
        else
            tb_op = eq ? gal_pkg::OP_MATCH : gal_pkg::OP_MISMATCH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= '0;
            tcnt_reg <= '0;
            h_reg <= '0;
            v_reg <= '0;
        end
        else
        begin
            if (cmd.load_pat && pcnt_reg != LW'(gal_pkg::MAX_LEN))
            begin
                pcnt_reg <= pcnt_reg + 1'b1;
            end
            if (cmd.load_txt && tcnt_reg != LW'(gal_pkg::MAX_LEN))
            begin
                tcnt_reg <= tcnt_reg + 1'b1;
            end
            if (cmd.clear_counts)
            begin
                pcnt_reg <= '0;
                tcnt_reg <= '0;
            end
            if (cmd.fill_start)
            begin
                h_reg <= '0;
                v_reg <= '0;
            end
            if (cmd.fill_write)
            begin
                if (v_reg == pcnt_reg)
                begin
                    v_reg <= '0;
                    h_reg <= h_reg + 1'b1;
                end
                else
                begin
                    v_reg <= v_reg + 1'b1;
                end
            end
            if (cmd.tb_start)
            begin
                h_reg <= tcnt_reg;
                v_reg <= pcnt_reg;
            end
            if (cmd.tb_step)
            begin
                if (tb_op == gal_pkg::OP_DELETION) v_reg <= vm1;
                else if (tb_op == gal_pkg::OP_INSERTION) h_reg <= hm1;
                else
                begin
                    h_reg <= hm1;
                    v_reg <= vm1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_write)
        begin
            dia_val_reg <= (v_reg == pcnt_reg) ? '0 : rd_b;
        end
    end

    // current cell value follows the move: neighbor read or diagonal cost removed
    always_ff @(posedge clk)
    begin
        if (cmd.tb_start)
        begin
            cur_reg <= score_reg;
        end
        else if (cmd.tb_step)
        begin
            if (tb_op == gal_pkg::OP_DELETION) cur_reg <= rd_a;
            else if (tb_op == gal_pkg::OP_INSERTION) cur_reg <= rd_b;
            else cur_reg <= cur_reg - (eq ? '0 : SW'(mis_pen));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_write && h_reg == tcnt_reg && v_reg == pcnt_reg)
        begin
            score_reg <= best;
        end
        if (cmd.out_load)
        begin
            out_score_reg <= score_reg;
            out_op_reg <= cmd.out_score_only ? gal_pkg::OP_MATCH : tb_op;
            out_opv_reg <= !cmd.out_score_only;
            out_last_reg <= cmd.out_score_only || sts.tb_last;
        end
    end

    logic [LW:0] hv_sum;
    assign hv_sum = {1'b0, h_reg} + {1'b0, v_reg};
    assign sts.fill_done = (h_reg == tcnt_reg) && (v_reg == pcnt_reg);
    assign sts.tb_done = (hv_sum == '0);
    assign sts.tb_last = (hv_sum == (LW+1)'(1)) ||
                         (h_reg != '0 && v_reg != '0 && hv_sum == (LW+1)'(2) &&
                          tb_op != gal_pkg::OP_DELETION && tb_op != gal_pkg::OP_INSERTION);
    assign sts.empty = !tb_en || (pcnt_reg == '0 && tcnt_reg == '0);

    assign score = out_score_reg;
    assign edit_op = out_op_reg;
    assign op_valid = out_opv_reg;
    assign last = out_last_reg;
endmodule

FILE: sv/gal_ctrl.sv
// controller state machine sequencing loads, table fill, traceback and output
`timescale 1ns / 1ps
module gal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        req_type,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gal_pkg::gal_cmd_t cmd,
    input  gal_pkg::gal_sts_t sts
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FRD   = 6'b000010,
        ST_FWR   = 6'b000100,
        ST_TRD   = 6'b001000,
        ST_TDEC  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   fin_reg, fin_next;

    logic in_acc;
    assign in_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign in_acc = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        fin_next = fin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (req_type)
                        gal_pkg::REQ_PATTERN: cmd.load_pat = 1'b1;
                        gal_pkg::REQ_TEXT: cmd.load_txt = 1'b1;
                        gal_pkg::REQ_ALIGN:
                        begin
                            cmd.fill_start = 1'b1;
                            state_next = ST_FRD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FRD:
            begin
                state_next = ST_FWR;
            end
            ST_FWR:
            begin
                cmd.fill_write = 1'b1;
                if (sts.fill_done)
                begin
                    state_next = ST_OUT;
                    fin_next = 1'b1;
                end
                else
                begin
                    state_next = ST_FRD;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    if (fin_reg && sts.empty)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_score_only = 1'b1;
                        cmd.clear_counts = 1'b1;
                        ov_next = 1'b1;
                        fin_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else if (fin_reg)
                    begin
                        cmd.tb_start = 1'b1;
                        fin_next = 1'b0;
                        state_next = ST_TRD;
                    end
                    else if (sts.tb_done)
                    begin
                        cmd.clear_counts = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_TRD;
                    end
                end
            end
            ST_TRD:
            begin
                cmd.tb_issue = 1'b1;
                state_next = ST_TDEC;
            end
            ST_TDEC:
            begin
                cmd.out_load = 1'b1;
                cmd.tb_step = 1'b1;
                ov_next = 1'b1;
                state_next = ST_OUT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            fin_reg <= fin_next;
        end
    end
endmodule

FILE: sv/global_alignment_linear_gap_core.sv
// top level of the linear-gap global alignment core
//  channel | dir | beat contents
//  in_ch   | in  | req_type, symbol
//  out_ch  | out | score, edit_op, op_valid, last
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// symbol loads are accepted in idle; align fills (T+1)*(P+1) cells, each through a
// read state and a write state on the single table ram, then traceback steps each op
// through a read, a decide and an output state, holding while the output is stalled.
// rst_n clears counts, penalties to 1 and traceback on; stores hold garbage.
// output stalls hold the traceback; input is refused until an align finishes.
`timescale 1ns / 1ps
module global_alignment_linear_gap_core (
    input  logic                            clk,
    input  logic                            rst_n,
    gal_in_if.sink                          in_ch,
    gal_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [gal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    logic [7:0] del_reg, ins_reg, mis_reg;
    logic       tb_reg;
    gal_pkg::gal_cmd_t cmd;
    gal_pkg::gal_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            del_reg <= 8'd1;
            ins_reg <= 8'd1;
            mis_reg <= 8'd1;
            tb_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gal_pkg::CFG_DEL: del_reg <= cfg_data;
                gal_pkg::CFG_INS: ins_reg <= cfg_data;
                gal_pkg::CFG_MIS: mis_reg <= cfg_data;
                gal_pkg::CFG_TB: tb_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    gal_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .req_type(in_ch.req_type),
        .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .sts(sts)
    );

    gal_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .symbol(in_ch.symbol),
        .del_pen(del_reg), .ins_pen(ins_reg), .mis_pen(mis_reg), .tb_en(tb_reg),
        .score(out_ch.score), .edit_op(out_ch.edit_op), .op_valid(out_ch.op_valid),
        .last(out_ch.last)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
    a_ops_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.op_valid) |-> out_ch.last)
        else $error("score-only beat not last");
`endif
endmodule
